@@ design/bmtl_pkg.sv @@
// Shared types, constants and helper functions for the bilinear map lookup core.
// Holds the axis breakpoints, segment reciprocals, default maps and lerp arithmetic.
// No dependencies.
package bmtl_pkg;

    localparam int TABLE_SIZE    = 8;
    localparam int IDX_W         = 3;
    localparam int CELL_W        = 2 * IDX_W;
    localparam int CELLS         = TABLE_SIZE * TABLE_SIZE;
    localparam int FRACTION_BITS = 16;
    localparam int VALUE_W       = 8;
    localparam int AXIS_W        = 16;
    localparam int WIDX_W        = 4;
    localparam int OP_W          = 2;
    localparam int MAPS          = 2;
    localparam int BANKS         = 4;
    localparam int BANK_ENTRIES  = CELLS / BANKS;
    localparam int BANK_AW       = 2 * (IDX_W - 1);

    localparam int LERP1_W = VALUE_W + FRACTION_BITS;
    localparam int LERP2_W = LERP1_W + FRACTION_BITS;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_EFF = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_ADV = 2'd2;

    localparam logic MAP_EFF = 1'b0;
    localparam logic MAP_ADV = 1'b1;

    localparam int SPD_D_W       = 9;
    localparam int SPD_RCP_W     = 26;
    localparam int SPD_RCP_SHIFT = 18;
    localparam int LOAD_D_W       = 12;
    localparam int LOAD_RCP_W     = 21;
    localparam int LOAD_RCP_SHIFT = 16;

    localparam logic [AXIS_W-1:0] SPD_BINS [TABLE_SIZE] = '{
        16'd500, 16'd1000, 16'd1500, 16'd2000, 16'd2500, 16'd3000, 16'd3500, 16'd4000
    };

    localparam logic [AXIS_W-1:0] LOAD_KNOTS [TABLE_SIZE] = '{
        16'd0, 16'd3072, 16'd6400, 16'd9472, 16'd12800, 16'd15872, 16'd19200, 16'd22272
    };

    // Reciprocals are rounded up so that the product shifted down gives the exact floor.
    localparam logic [SPD_RCP_W-1:0] SPD_RCP [TABLE_SIZE] = '{
        26'd34359739, 26'd34359739, 26'd34359739, 26'd34359739,
        26'd34359739, 26'd34359739, 26'd34359739, 26'd0
    };

    localparam logic [LOAD_RCP_W-1:0] LOAD_RCP [TABLE_SIZE] = '{
        21'd1398102, 21'd1290556, 21'd1398102, 21'd1290556,
        21'd1398102, 21'd1290556, 21'd1398102, 21'd0
    };

    localparam logic [VALUE_W-1:0] EFF_DEFAULT [CELLS] = '{
        8'd80, 8'd85, 8'd90, 8'd95, 8'd100, 8'd105, 8'd110, 8'd115,
        8'd82, 8'd87, 8'd92, 8'd97, 8'd102, 8'd107, 8'd112, 8'd117,
        8'd84, 8'd89, 8'd94, 8'd99, 8'd104, 8'd109, 8'd114, 8'd119,
        8'd86, 8'd91, 8'd96, 8'd101, 8'd106, 8'd111, 8'd116, 8'd121,
        8'd88, 8'd93, 8'd98, 8'd103, 8'd108, 8'd113, 8'd118, 8'd123,
        8'd90, 8'd95, 8'd100, 8'd105, 8'd110, 8'd115, 8'd120, 8'd125,
        8'd92, 8'd97, 8'd102, 8'd107, 8'd112, 8'd117, 8'd122, 8'd127,
        8'd94, 8'd99, 8'd104, 8'd109, 8'd114, 8'd119, 8'd124, 8'd129
    };

    localparam logic [VALUE_W-1:0] ADV_DEFAULT [CELLS] = '{
        8'd5, 8'd6, 8'd8, 8'd10, 8'd12, 8'd14, 8'd16, 8'd18,
        8'd6, 8'd7, 8'd9, 8'd11, 8'd13, 8'd15, 8'd17, 8'd19,
        8'd7, 8'd8, 8'd10, 8'd12, 8'd14, 8'd16, 8'd18, 8'd20,
        8'd8, 8'd9, 8'd11, 8'd13, 8'd15, 8'd17, 8'd19, 8'd21,
        8'd9, 8'd10, 8'd12, 8'd14, 8'd16, 8'd18, 8'd20, 8'd22,
        8'd10, 8'd11, 8'd13, 8'd15, 8'd17, 8'd19, 8'd21, 8'd23,
        8'd11, 8'd12, 8'd14, 8'd16, 8'd18, 8'd20, 8'd22, 8'd24,
        8'd12, 8'd13, 8'd15, 8'd17, 8'd19, 8'd21, 8'd23, 8'd25
    };

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
        logic en_out;
    } t_pipe_en;

    typedef struct packed {
        logic               en;
        logic               map;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [VALUE_W-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic [VALUE_W-1:0] v00;
        logic [VALUE_W-1:0] v01;
        logic [VALUE_W-1:0] v10;
        logic [VALUE_W-1:0] v11;
    } t_corners;

    function automatic logic [VALUE_W-1:0] dflt_value(
        input logic             map,
        input logic [IDX_W-1:0] row,
        input logic [IDX_W-1:0] col
    );
        logic [CELL_W-1:0] slot;
        slot = {row, col};
        return (map == MAP_ADV) ? ADV_DEFAULT[slot] : EFF_DEFAULT[slot];
    endfunction

    function automatic logic [LERP1_W-1:0] lerp_load(
        input logic [VALUE_W-1:0]       lo,
        input logic [VALUE_W-1:0]       hi,
        input logic [FRACTION_BITS-1:0] f
    );
        logic signed [VALUE_W:0]   diff;
        logic signed [LERP1_W+1:0] prod;
        logic signed [LERP1_W+1:0] sum;
        diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
        prod = diff * $signed({1'b0, f});
        sum  = $signed({2'b00, lo, {FRACTION_BITS{1'b0}}}) + prod;
        return sum[LERP1_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] lerp_speed(
        input logic [LERP1_W-1:0]       lo,
        input logic [LERP1_W-1:0]       hi,
        input logic [FRACTION_BITS-1:0] f
    );
        logic signed [LERP1_W:0]   diff;
        logic signed [LERP2_W+1:0] prod;
        logic signed [LERP2_W+1:0] sum;
        diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
        prod = diff * $signed({1'b0, f});
        sum  = $signed({2'b00, lo, {FRACTION_BITS{1'b0}}}) + prod;
        return sum[LERP2_W-1 -: VALUE_W];
    endfunction

endpackage

@@ design/bmtl_locate.sv @@
// Axis locator: clamps speed and load, finds the bracketing segment and its fraction.
// Stage one holds segment and offset, stage two holds the reciprocal-based fractions.
// Depends on bmtl_pkg.
module bmtl_locate (
    input  logic                              i_clk,
    input  bmtl_pkg::t_pipe_en                i_en,
    input  logic [bmtl_pkg::AXIS_W-1:0]        i_speed,
    input  logic [bmtl_pkg::AXIS_W-1:0]        i_load,
    output logic [bmtl_pkg::IDX_W-1:0]         o_s1_row,
    output logic [bmtl_pkg::IDX_W-1:0]         o_s1_col,
    output logic [bmtl_pkg::FRACTION_BITS-1:0] o_s2_frac_row,
    output logic [bmtl_pkg::FRACTION_BITS-1:0] o_s2_frac_col
);
    import bmtl_pkg::*;

    localparam int SPD_PROD_W  = SPD_D_W + SPD_RCP_W;
    localparam int LOAD_PROD_W = LOAD_D_W + LOAD_RCP_W;

    logic [IDX_W-1:0]  n_spd_seg;
    logic [AXIS_W-1:0] n_spd_diff;
    logic              n_spd_zero;
    logic [IDX_W-1:0]  n_load_seg;
    logic [AXIS_W-1:0] n_load_diff;
    logic              n_load_zero;

    logic [IDX_W-1:0]    r_s1_spd_seg;
    logic [SPD_D_W-1:0]  r_s1_spd_d;
    logic                r_s1_spd_zero;
    logic [IDX_W-1:0]    r_s1_load_seg;
    logic [LOAD_D_W-1:0] r_s1_load_d;
    logic                r_s1_load_zero;

    logic [SPD_PROD_W-1:0]    spd_prod;
    logic [LOAD_PROD_W-1:0]   load_prod;
    logic [FRACTION_BITS-1:0] n_frac_row;
    logic [FRACTION_BITS-1:0] n_frac_col;

    logic [FRACTION_BITS-1:0] r_s2_frac_row;
    logic [FRACTION_BITS-1:0] r_s2_frac_col;

    always_comb begin
        n_spd_seg  = '0;
        n_load_seg = '0;
        for (int k = 1; k < TABLE_SIZE - 1; k++) begin
            if (i_speed >= SPD_BINS[k]) begin
                n_spd_seg = IDX_W'(k);
            end
            if (i_load >= LOAD_KNOTS[k]) begin
                n_load_seg = IDX_W'(k);
            end
        end
        n_spd_zero  = (i_speed <= SPD_BINS[0]) || (i_speed >= SPD_BINS[TABLE_SIZE-1]);
        n_load_zero = (i_load <= LOAD_KNOTS[0]) || (i_load >= LOAD_KNOTS[TABLE_SIZE-1]);
        if (i_speed >= SPD_BINS[TABLE_SIZE-1]) begin
            n_spd_seg = IDX_W'(TABLE_SIZE - 1);
        end
        if (i_load >= LOAD_KNOTS[TABLE_SIZE-1]) begin
            n_load_seg = IDX_W'(TABLE_SIZE - 1);
        end
        n_spd_diff  = i_speed - SPD_BINS[n_spd_seg];
        n_load_diff = i_load - LOAD_KNOTS[n_load_seg];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en1) begin
            r_s1_spd_seg   <= n_spd_seg;
            r_s1_spd_d     <= n_spd_diff[SPD_D_W-1:0];
            r_s1_spd_zero  <= n_spd_zero;
            r_s1_load_seg  <= n_load_seg;
            r_s1_load_d    <= n_load_diff[LOAD_D_W-1:0];
            r_s1_load_zero <= n_load_zero;
        end
    end

    assign spd_prod  = {{SPD_RCP_W{1'b0}}, r_s1_spd_d} *
                       {{SPD_D_W{1'b0}}, SPD_RCP[r_s1_spd_seg]};
    assign load_prod = {{LOAD_RCP_W{1'b0}}, r_s1_load_d} *
                       {{LOAD_D_W{1'b0}}, LOAD_RCP[r_s1_load_seg]};

    assign n_frac_row = r_s1_spd_zero  ? '0 : spd_prod[SPD_RCP_SHIFT +: FRACTION_BITS];
    assign n_frac_col = r_s1_load_zero ? '0 : load_prod[LOAD_RCP_SHIFT +: FRACTION_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_s2_frac_row <= n_frac_row;
            r_s2_frac_col <= n_frac_col;
        end
    end

    assign o_s1_row      = r_s1_spd_seg;
    assign o_s1_col      = r_s1_load_seg;
    assign o_s2_frac_row = r_s2_frac_row;
    assign o_s2_frac_col = r_s2_frac_col;

endmodule

@@ design/bmtl_map_store.sv @@
// Map storage: both byte maps, each split into four banks by row and column parity.
// Entries never written read as the default map; the four corners come out registered.
// Depends on bmtl_pkg.
module bmtl_map_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bmtl_pkg::t_pipe_en        i_en,
    input  bmtl_pkg::t_wr_req         i_wr,
    input  logic [bmtl_pkg::IDX_W-1:0] i_row_lo,
    input  logic [bmtl_pkg::IDX_W-1:0] i_col_lo,
    output bmtl_pkg::t_corners        o_eff,
    output bmtl_pkg::t_corners        o_adv
);
    import bmtl_pkg::*;

    logic [IDX_W-1:0]   row_hi;
    logic [IDX_W-1:0]   col_hi;
    logic [IDX_W-1:0]   row_sel [2];
    logic [IDX_W-1:0]   col_sel [2];
    logic [IDX_W-1:0]   rd_row  [BANKS];
    logic [IDX_W-1:0]   rd_col  [BANKS];
    logic [BANK_AW-1:0] rd_addr [BANKS];
    logic [1:0]         wr_bank;
    logic [BANK_AW-1:0] wr_addr;

    logic [VALUE_W-1:0]      r_mem     [MAPS][BANKS][BANK_ENTRIES];
    logic [BANK_ENTRIES-1:0] r_valid   [MAPS][BANKS];
    logic [VALUE_W-1:0]      r_rd_data [MAPS][BANKS];
    logic [VALUE_W-1:0]      r_rd_dflt [MAPS][BANKS];
    logic                    r_rd_valid[MAPS][BANKS];
    logic                    r_row_par;
    logic                    r_col_par;

    logic [VALUE_W-1:0] bank_val [MAPS][BANKS];
    t_corners           corners  [MAPS];

    assign row_hi = (i_row_lo == IDX_W'(TABLE_SIZE - 1)) ? i_row_lo - 1'b1 : i_row_lo + 1'b1;
    assign col_hi = (i_col_lo == IDX_W'(TABLE_SIZE - 1)) ? i_col_lo - 1'b1 : i_col_lo + 1'b1;

    assign row_sel[0] = i_row_lo[0] ? row_hi : i_row_lo;
    assign row_sel[1] = i_row_lo[0] ? i_row_lo : row_hi;
    assign col_sel[0] = i_col_lo[0] ? col_hi : i_col_lo;
    assign col_sel[1] = i_col_lo[0] ? i_col_lo : col_hi;

    always_comb begin
        for (int b = 0; b < BANKS; b++) begin
            rd_row[b]  = row_sel[b / 2];
            rd_col[b]  = col_sel[b % 2];
            rd_addr[b] = {rd_row[b][IDX_W-1:1], rd_col[b][IDX_W-1:1]};
        end
    end

    assign wr_bank = {i_wr.row[0], i_wr.col[0]};
    assign wr_addr = {i_wr.row[IDX_W-1:1], i_wr.col[IDX_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.map][wr_bank][wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '{default: '0};
        end else if (i_wr.en) begin
            r_valid[i_wr.map][wr_bank][wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            for (int m = 0; m < MAPS; m++) begin
                for (int b = 0; b < BANKS; b++) begin
                    r_rd_data[m][b]  <= r_mem[m][b][rd_addr[b]];
                    r_rd_valid[m][b] <= r_valid[m][b][rd_addr[b]];
                    r_rd_dflt[m][b]  <= dflt_value(1'(m), rd_row[b], rd_col[b]);
                end
            end
            r_row_par <= i_row_lo[0];
            r_col_par <= i_col_lo[0];
        end
    end

    always_comb begin
        for (int m = 0; m < MAPS; m++) begin
            for (int b = 0; b < BANKS; b++) begin
                bank_val[m][b] = r_rd_valid[m][b] ? r_rd_data[m][b] : r_rd_dflt[m][b];
            end
            corners[m].v00 = bank_val[m][{r_row_par, r_col_par}];
            corners[m].v01 = bank_val[m][{r_row_par, ~r_col_par}];
            corners[m].v10 = bank_val[m][{~r_row_par, r_col_par}];
            corners[m].v11 = bank_val[m][{~r_row_par, ~r_col_par}];
        end
    end

    assign o_eff = corners[MAP_EFF];
    assign o_adv = corners[MAP_ADV];

endmodule

@@ design/bmtl_blend.sv @@
// Bilinear blend: lerp along load into stage three, then along speed into the output register.
// Works on both maps side by side.
// Depends on bmtl_pkg.
module bmtl_blend (
    input  logic                              i_clk,
    input  bmtl_pkg::t_pipe_en                i_en,
    input  bmtl_pkg::t_corners                i_eff,
    input  bmtl_pkg::t_corners                i_adv,
    input  logic [bmtl_pkg::FRACTION_BITS-1:0] i_frac_row,
    input  logic [bmtl_pkg::FRACTION_BITS-1:0] i_frac_col,
    output logic [bmtl_pkg::VALUE_W-1:0]       o_eff,
    output logic [bmtl_pkg::VALUE_W-1:0]       o_adv
);
    import bmtl_pkg::*;

    logic [LERP1_W-1:0]       r_s3_eff_a0;
    logic [LERP1_W-1:0]       r_s3_eff_a1;
    logic [LERP1_W-1:0]       r_s3_adv_a0;
    logic [LERP1_W-1:0]       r_s3_adv_a1;
    logic [FRACTION_BITS-1:0] r_s3_frac_row;
    logic [VALUE_W-1:0]       r_eff;
    logic [VALUE_W-1:0]       r_adv;

    logic [VALUE_W-1:0] n_eff;
    logic [VALUE_W-1:0] n_adv;

    always_ff @(posedge i_clk) begin
        if (i_en.en3) begin
            r_s3_eff_a0   <= lerp_load(i_eff.v00, i_eff.v01, i_frac_col);
            r_s3_eff_a1   <= lerp_load(i_eff.v10, i_eff.v11, i_frac_col);
            r_s3_adv_a0   <= lerp_load(i_adv.v00, i_adv.v01, i_frac_col);
            r_s3_adv_a1   <= lerp_load(i_adv.v10, i_adv.v11, i_frac_col);
            r_s3_frac_row <= i_frac_row;
        end
    end

    assign n_eff = lerp_speed(r_s3_eff_a0, r_s3_eff_a1, r_s3_frac_row);
    assign n_adv = lerp_speed(r_s3_adv_a0, r_s3_adv_a1, r_s3_frac_row);

    always_ff @(posedge i_clk) begin
        if (i_en.en_out) begin
            r_eff <= n_eff;
            r_adv <= n_adv;
        end
    end

    assign o_eff = r_eff;
    assign o_adv = r_adv;

endmodule

@@ design/bilinear_map_table_lookup_core.sv @@
// Top level of the bilinear map lookup core: stream ports, pipeline control, map writes.
// Instantiates bmtl_locate, bmtl_map_store and bmtl_blend; depends on bmtl_pkg.
//
// Usage:
// The slave stream carries one command word per handshake; tuser selects a lookup
// of both maps, a write to the efficiency map or a write to the advance map.
// A lookup returns one master stream word with the efficiency and advance bytes.
// Writes and unknown commands are consumed and return no word.
// A lookup's result passes all of the four-stage pipeline (locate, multiply and bank
// read, load lerp, speed lerp) before it is presented. The pipelining sets the
// throughput: one word per cycle in both directions while the receiver does not stall.
// A write updates the maps as it leaves the first stage, so a lookup accepted on
// the very next cycle already sees the new byte.
// Reset empties the pipeline and returns both maps to their default contents at once.
// When the receiver stalls, the pipeline holds every word, empty stages still fill,
// and s_axis_tready drops only once all four stages hold a word.
module bilinear_map_table_lookup_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] engine_speed, [31:16] engine_load, [35:32] row_index,
    // [39:36] column_index, [47:40] entry_value
    input  logic [47:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] efficiency_value, [15:8] advance_value
    output logic [15:0] m_axis_tdata
);
    import bmtl_pkg::*;

    logic [OP_W-1:0]    in_op;
    logic [AXIS_W-1:0]  in_speed;
    logic [AXIS_W-1:0]  in_load;
    logic [WIDX_W-1:0]  in_row;
    logic [WIDX_W-1:0]  in_col;
    logic [VALUE_W-1:0] in_value;

    t_pipe_en pipe_en;
    t_wr_req  wr_req;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vo;

    logic [OP_W-1:0]    r_s1_op;
    logic [WIDX_W-1:0]  r_s1_row;
    logic [WIDX_W-1:0]  r_s1_col;
    logic [VALUE_W-1:0] r_s1_value;

    logic [IDX_W-1:0]         s1_row;
    logic [IDX_W-1:0]         s1_col;
    logic [FRACTION_BITS-1:0] s2_frac_row;
    logic [FRACTION_BITS-1:0] s2_frac_col;
    t_corners                 s2_eff;
    t_corners                 s2_adv;
    logic [VALUE_W-1:0]       out_eff;
    logic [VALUE_W-1:0]       out_adv;

    assign in_op    = s_axis_tuser;
    assign in_speed = s_axis_tdata[15:0];
    assign in_load  = s_axis_tdata[31:16];
    assign in_row   = s_axis_tdata[35:32];
    assign in_col   = s_axis_tdata[39:36];
    assign in_value = s_axis_tdata[47:40];

    assign pipe_en.en_out = !r_vo || m_axis_tready;
    assign pipe_en.en3    = !r_v3 || pipe_en.en_out;
    assign pipe_en.en2    = !r_v2 || pipe_en.en3;
    assign pipe_en.en1    = !r_v1 || pipe_en.en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (pipe_en.en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (pipe_en.en2) begin
                r_v2 <= r_v1 && (r_s1_op == OP_LOOKUP);
            end
            if (pipe_en.en3) begin
                r_v3 <= r_v2;
            end
            if (pipe_en.en_out) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en.en1) begin
            r_s1_op    <= in_op;
            r_s1_row   <= in_row;
            r_s1_col   <= in_col;
            r_s1_value <= in_value;
        end
    end

    assign wr_req.en   = r_v1 && pipe_en.en2
                         && ((r_s1_op == OP_WR_EFF) || (r_s1_op == OP_WR_ADV))
                         && (r_s1_row < WIDX_W'(TABLE_SIZE))
                         && (r_s1_col < WIDX_W'(TABLE_SIZE));
    assign wr_req.map  = (r_s1_op == OP_WR_ADV) ? MAP_ADV : MAP_EFF;
    assign wr_req.row  = r_s1_row[IDX_W-1:0];
    assign wr_req.col  = r_s1_col[IDX_W-1:0];
    assign wr_req.data = r_s1_value;

    bmtl_locate u_locate (
        .i_clk         (i_clk),
        .i_en          (pipe_en),
        .i_speed       (in_speed),
        .i_load        (in_load),
        .o_s1_row      (s1_row),
        .o_s1_col      (s1_col),
        .o_s2_frac_row (s2_frac_row),
        .o_s2_frac_col (s2_frac_col)
    );

    bmtl_map_store u_map_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (pipe_en),
        .i_wr     (wr_req),
        .i_row_lo (s1_row),
        .i_col_lo (s1_col),
        .o_eff    (s2_eff),
        .o_adv    (s2_adv)
    );

    bmtl_blend u_blend (
        .i_clk      (i_clk),
        .i_en       (pipe_en),
        .i_eff      (s2_eff),
        .i_adv      (s2_adv),
        .i_frac_row (s2_frac_row),
        .i_frac_col (s2_frac_col),
        .o_eff      (out_eff),
        .o_adv      (out_adv)
    );

    assign s_axis_tready = pipe_en.en1;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {out_adv, out_eff};

    a_ready_when_out_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input not ready although the output stage is empty");

    a_full_stall_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready && r_v3 && r_v2 && r_v1) |-> !s_axis_tready
    ) else $error("input accepted while every stage is full and the output stalls");

    a_stage2_only_lookups: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && $past(pipe_en.en2)) |-> $past(r_v1 && (r_s1_op == OP_LOOKUP))
    ) else $error("a non-lookup word entered the blend stages");

endmodule

@@ test/tb.sv @@
// Testbench for bilinear_map_table_lookup_core: random and directed stream traffic.
// Lookups and map writes are predicted in order and each result word is checked.
// Depends on bmtl_pkg and the core RTL.
module tb;
    import bmtl_pkg::*;

    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_PCT     = 18;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [VALUE_W-1:0] adv;
        logic [VALUE_W-1:0] eff;
    } t_map_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    logic [VALUE_W-1:0] eff_map [CELLS];
    logic [VALUE_W-1:0] adv_map [CELLS];
    t_map_pair pending_lookups [$];

    int  mismatches = 0;
    int  lookups_sent = 0;
    int  writes_sent = 0;
    int  ignored_sent = 0;
    int  lookups_checked = 0;
    int  quiet_cycles = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    bilinear_map_table_lookup_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic int unsigned axis_knot(input bit on_load, input int i);
        if (!on_load) begin
            return 500 * (i + 1);
        end
        case (i)
            0: begin
                return 0;
            end
            1: begin
                return 12 * 256;
            end
            2: begin
                return 25 * 256;
            end
            3: begin
                return 37 * 256;
            end
            4: begin
                return 50 * 256;
            end
            5: begin
                return 62 * 256;
            end
            6: begin
                return 75 * 256;
            end
            default: begin
                return 87 * 256;
            end
        endcase
    endfunction

    function automatic void locate_axis(input bit on_load, input int unsigned x,
                                        output int lo, output int hi, output longint frac);
        int i;
        frac = 0;
        lo = TABLE_SIZE - 1;
        hi = TABLE_SIZE - 1;
        if (x <= axis_knot(on_load, 0)) begin
            lo = 0;
            hi = 0;
        end else if (x < axis_knot(on_load, TABLE_SIZE - 1)) begin
            for (i = 0; i < TABLE_SIZE - 1; i++) begin
                if (x >= axis_knot(on_load, i) && x < axis_knot(on_load, i + 1)) begin
                    lo = i;
                    hi = i + 1;
                    frac = (longint'(x - axis_knot(on_load, i)) << FRACTION_BITS) /
                           longint'(axis_knot(on_load, i + 1) - axis_knot(on_load, i));
                end
            end
        end
    endfunction

    function automatic logic [VALUE_W-1:0] blend_map(input bit advance, input int r0, r1,
                                                     c0, c1, input longint fr, fc);
        longint s, v00, v01, v10, v11, a0, a1, acc;
        s = longint'(1) << FRACTION_BITS;
        if (advance) begin
            v00 = adv_map[r0 * TABLE_SIZE + c0];
            v01 = adv_map[r0 * TABLE_SIZE + c1];
            v10 = adv_map[r1 * TABLE_SIZE + c0];
            v11 = adv_map[r1 * TABLE_SIZE + c1];
        end else begin
            v00 = eff_map[r0 * TABLE_SIZE + c0];
            v01 = eff_map[r0 * TABLE_SIZE + c1];
            v10 = eff_map[r1 * TABLE_SIZE + c0];
            v11 = eff_map[r1 * TABLE_SIZE + c1];
        end
        a0 = v00 * s + (v01 - v00) * fc;
        a1 = v10 * s + (v11 - v10) * fc;
        acc = a0 * s + (a1 - a0) * fr;
        return VALUE_W'(acc >> (2 * FRACTION_BITS));
    endfunction

    task automatic record_word(input logic [OP_W-1:0] op, input logic [15:0] speed, load,
                               input logic [3:0] row, col, input logic [7:0] val);
        int r0, r1, c0, c1;
        longint fr, fc;
        t_map_pair want;
        if (op == OP_LOOKUP) begin
            locate_axis(1'b0, speed, r0, r1, fr);
            locate_axis(1'b1, load, c0, c1, fc);
            want.eff = blend_map(1'b0, r0, r1, c0, c1, fr, fc);
            want.adv = blend_map(1'b1, r0, r1, c0, c1, fr, fc);
            pending_lookups.push_back(want);
            lookups_sent++;
        end else if ((op == OP_WR_EFF || op == OP_WR_ADV) && row < TABLE_SIZE
                     && col < TABLE_SIZE) begin
            if (op == OP_WR_EFF) begin
                eff_map[row * TABLE_SIZE + col] = val;
            end else begin
                adv_map[row * TABLE_SIZE + col] = val;
            end
            writes_sent++;
        end else begin
            ignored_sent++;
        end
    endtask

    task automatic send_word(input logic [OP_W-1:0] op, input logic [15:0] speed, load,
                             input logic [3:0] row, col, input logic [7:0] val);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {val, col, row, load, speed};
        do @(posedge i_clk); while (!s_axis_tready);
        record_word(op, speed, load, row, col, val);
        @(negedge i_clk);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_lookups.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_speed();
        case ($urandom_range(9))
            0: begin
                return 16'(500 * $urandom_range(1, 8));
            end
            1: begin
                return 16'($urandom_range(65535));
            end
            default: begin
                return 16'($urandom_range(4000, 500));
            end
        endcase
    endfunction

    function automatic logic [15:0] rand_load();
        case ($urandom_range(9))
            0: begin
                return 16'(axis_knot(1'b1, $urandom_range(7)));
            end
            1: begin
                return 16'($urandom_range(65535));
            end
            default: begin
                return 16'($urandom_range(87 * 256));
            end
        endcase
    endfunction

    function automatic logic [3:0] rand_index();
        return ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    endfunction

    task automatic send_random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            send_word(OP_LOOKUP, rand_speed(), rand_load(), 4'($urandom_range(15)),
                      4'($urandom_range(15)), 8'($urandom_range(255)));
        end else if (pick < 72) begin
            send_word(OP_WR_EFF, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      rand_index(), rand_index(), 8'($urandom_range(255)));
        end else if (pick < 94) begin
            send_word(OP_WR_ADV, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      rand_index(), rand_index(), 8'($urandom_range(255)));
        end else begin
            send_word(OP_IGNORED, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                      4'($urandom_range(15)), 4'($urandom_range(15)),
                      8'($urandom_range(255)));
        end
    endtask

    task automatic test_directed_corners();
        send_word(OP_LOOKUP, 16'd0, 16'd0, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd500, 16'd0, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'hFFFF, 16'hFFFF, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd4000, 16'd22272, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd499, 16'd1, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd501, 16'd3071, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd3999, 16'd22271, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd1000, 16'd3072, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd2250, 16'd8000, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd0, 16'hFFFF, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'hFFFF, 16'd0, 4'd0, 4'd0, 8'd0);
        send_word(OP_WR_EFF, 16'd0, 16'd0, 4'd7, 4'd7, 8'd255);
        send_word(OP_LOOKUP, 16'd4000, 16'd22272, 4'd0, 4'd0, 8'd0);
        send_word(OP_WR_ADV, 16'd0, 16'd0, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd0, 16'd0, 4'd0, 4'd0, 8'd0);
        send_word(OP_WR_EFF, 16'd0, 16'd0, 4'd8, 4'd0, 8'd255);
        send_word(OP_WR_ADV, 16'd0, 16'd0, 4'd0, 4'd15, 8'd255);
        send_word(OP_IGNORED, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 8'd255);
        send_word(OP_WR_EFF, 16'd0, 16'd0, 4'd3, 4'd4, 8'd0);
        send_word(OP_WR_EFF, 16'd0, 16'd0, 4'd3, 4'd5, 8'd255);
        send_word(OP_WR_ADV, 16'd0, 16'd0, 4'd4, 4'd5, 8'd255);
        send_word(OP_LOOKUP, 16'd2250, 16'd14000, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd2000, 16'd15871, 4'd0, 4'd0, 8'd0);
        send_word(OP_LOOKUP, 16'd0, 16'd0, 4'd0, 4'd0, 8'd0);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int words);
        int goal;
        goal = lookups_sent + writes_sent + words;
        while (lookups_sent + writes_sent < goal) begin
            send_random_word();
        end
        wait_all_results();
    endtask

    task automatic test_back_pressure();
        int n;
        hold_req = 1'b1;
        for (n = 0; n < 40; n++) begin
            send_word(OP_LOOKUP, rand_speed(), rand_load(), 4'd0, 4'd0, 8'd0);
        end
        wait_all_results();
    endtask

    task automatic test_no_idle_stretch(input int words);
        idle_on = 1'b0;
        test_random_traffic(words);
        idle_on = 1'b1;
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_map_pair want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_lookups.size() == 0) begin
                $display("%0t: result word %h with no lookup outstanding", $time, m_axis_tdata);
                mismatches++;
            end else begin
                want = pending_lookups.pop_front();
                lookups_checked++;
                if (m_axis_tdata[7:0] !== want.eff) begin
                    $display("%0t: efficiency expected %0d, got %0d", $time, want.eff,
                             m_axis_tdata[7:0]);
                    mismatches++;
                end
                if (m_axis_tdata[15:8] !== want.adv) begin
                    $display("%0t: advance expected %0d, got %0d", $time, want.adv,
                             m_axis_tdata[15:8]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < CELLS; i++) begin
            eff_map[i] = EFF_DEFAULT[i];
            adv_map[i] = ADV_DEFAULT[i];
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_corners();
        test_random_traffic(320);
        test_back_pressure();
        test_no_idle_stretch(220);
        test_random_traffic(240);
        $display("Covered %0d lookups and %0d map writes, plus %0d ignored words,",
                 lookups_checked, writes_sent, ignored_sent);
        $display("with clamped axes, exact breakpoints, a long output stall and idle gaps.");
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

@@ files.f @@
design/bmtl_pkg.sv
design/bmtl_locate.sv
design/bmtl_map_store.sv
design/bmtl_blend.sv
design/bilinear_map_table_lookup_core.sv
test/tb.sv
